// ===== src/rtg_pkg.sv =====
package rtg_pkg;

    // Beat payloads
    typedef struct packed {
        logic [14:0] rpm;
        logic        ignition_on;
    } rtg_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               last_of_run;
    } rtg_out_t;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE   = 2'd2;

    localparam logic [27:0] PHASE_STEP_RST = 28'd18325194;
    localparam logic [15:0] VOLUME_RST     = 16'd2048;
    localparam logic [21:0] RESAMPLE_RST   = 22'd314573;

    localparam logic [14:0] RPM_FLOOR = 15'd100;
    localparam logic [14:0] MAG_MAX   = 15'h7fff;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(j * pi/2 / 2^qbits) in Q30, truncating Horner series to the 9th power.
    // Only evaluated at elaboration to build the quarter-wave table.
    function automatic logic [30:0] sine_entry(input int unsigned j, input int unsigned qbits);
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] s;
        theta = (64'(j) * HALF_PI_Q30) >> qbits;
        t2    = (theta * theta) >> 30;
        r     = Q30_ONE - t2 / 64'd72;
        r     = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
        r     = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
        r     = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
        s     = (theta * r) >> 30;
        return s[30:0];
    endfunction

endpackage

// ===== src/rtg_sine_rom.sv =====
module rtg_sine_rom
    import rtg_pkg::*;
#(
    parameter int QBITS = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [QBITS:0] rd_addr,
    output logic [30:0]   rd_data
);

    // quarter wave, both end points included
    localparam int DEPTH = (1 << QBITS) + 1;

    logic [30:0] rom_tbl [0:DEPTH-1];
    logic [30:0] data_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        localparam logic [30:0] Entry = sine_entry(g, QBITS);
        assign rom_tbl[g] = Entry;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= rom_tbl[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

// ===== src/rpm_tone_generator_upsampler.sv =====
// Engine tone oscillator with zero-order-hold upsampler. Each item beat is one
// simulation tick (rpm, ignition_on); it yields floor(fraction + resample_step)
// result beats, all carrying the same sample, the final one flagged with
// last_of_run (a tick may yield none). The tone is rpm/6 Hz from a phase
// accumulator and a quarter-wave sine table, scaled by volume_gain, clamped to
// +-32767 and truncated towards zero; silence (ignition off or rpm zero) holds
// the phase. Item beats pass a five-register pipeline (input, phase/fraction,
// sine table read, gain multiply, output hold), and a new item enters every
// cycle while the pipeline does not stall. The sustained rate is set by the
// output register, which sends one result beat per cycle while result_ready
// is high. item_ready follows result_ready combinationally through the
// pipeline stalls. Configuration writes (index 0 phase step per rpm, 1 volume,
// 2 resample step; other indexes ignored) are always taken and must be made
// while the block is idle.
module rpm_tone_generator_upsampler
    import rtg_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  rtg_in_t               item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rtg_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QBITS  = SINE_ADDR_BITS - 2;
    localparam int JW     = QBITS + 1;
    localparam int INCR_W = (PHASE_BITS > 35) ? PHASE_BITS : 35;
    localparam logic [JW-1:0] QUARTER = JW'(1) << QBITS;

    // configuration
    logic [27:0] step_reg;
    logic [15:0] gain_reg;
    logic [21:0] rstep_reg;

    // state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [15:0]           frac_reg;

    // stage 1: input register
    logic        s1_valid_reg;
    logic [14:0] s1_rpm_reg;
    logic        s1_ign_reg;

    // stage 2: phase increment
    logic                  s2_valid_reg;
    logic [PHASE_BITS-1:0] s2_incr_reg;
    logic                  s2_active_reg;

    // stage 3: sine table word
    logic        s3_valid_reg;
    logic        s3_neg_reg;
    logic        s3_active_reg;
    logic [6:0]  s3_count_reg;
    logic [30:0] s3_sine;

    // stage 4: gained magnitude
    logic        s4_valid_reg;
    logic [46:0] s4_gprod_reg;
    logic        s4_neg_reg;
    logic        s4_active_reg;
    logic [6:0]  s4_count_reg;

    // output hold
    logic        out_valid_reg;
    logic [15:0] sample_reg;
    logic [6:0]  rem_reg;

    logic s1_adv, s2_adv, s3_adv, s4_adv, out_free, out_load;

    // ---- handshakes and stall chain ----
    assign out_free   = !out_valid_reg || (result_ready && rem_reg == 7'd1);
    assign s4_adv     = s4_valid_reg && (s4_count_reg == 7'd0 || out_free);
    assign out_load   = s4_adv && s4_count_reg != 7'd0;
    assign s3_adv     = s3_valid_reg && (!s4_valid_reg || s4_adv);
    assign s2_adv     = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign item_ready = !s1_valid_reg || s1_adv;
    assign cfg_ready  = 1'b1;

    // ---- stage 1 logic: rpm floor and phase increment ----
    logic              s1_active;
    logic [14:0]       s1_eff;
    logic [42:0]       rate_prod;
    logic [INCR_W-1:0] incr_wide;

    assign s1_active = s1_ign_reg && s1_rpm_reg != 15'd0;
    assign s1_eff    = (s1_rpm_reg < RPM_FLOOR) ? RPM_FLOOR : s1_rpm_reg;
    assign rate_prod = 43'(s1_eff) * 43'(step_reg);
    assign incr_wide = INCR_W'(rate_prod[42:8]);

    // ---- stage 2 logic: table address and upsampler count ----
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [QBITS-1:0]          k;
    logic [JW-1:0]             j;
    logic [22:0]               frac_sum;

    assign idx      = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign k        = idx[QBITS-1:0];
    assign j        = idx[QBITS] ? (QUARTER - JW'(k)) : JW'(k);
    assign frac_sum = 23'(frac_reg) + 23'(rstep_reg);

    rtg_sine_rom #(
        .QBITS (QBITS)
    ) u_rom (
        .clk     (clk),
        .rd_en   (s2_adv),
        .rd_addr (j),
        .rd_data (s3_sine)
    );

    // ---- stage 4 logic: full-scale, clamp, sign ----
    logic [61:0] scaled;
    logic [19:0] mag_raw;
    logic [14:0] mag;
    logic [15:0] sample_next;

    assign scaled  = (62'(s4_gprod_reg) << 15) - 62'(s4_gprod_reg);
    assign mag_raw = scaled[61:42];
    assign mag     = (mag_raw > 20'(MAG_MAX)) ? MAG_MAX : mag_raw[14:0];

    always_comb
    begin
        if (!s4_active_reg)
        begin
            sample_next = 16'd0;
        end
        else if (s4_neg_reg)
        begin
            sample_next = 16'd0 - {1'b0, mag};
        end
        else
        begin
            sample_next = {1'b0, mag};
        end
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= PHASE_STEP_RST;
            gain_reg      <= VOLUME_RST;
            rstep_reg     <= RESAMPLE_RST;
            phase_reg     <= '0;
            frac_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PHASE_STEP: step_reg  <= cfg_data[27:0];
                    CFG_VOLUME:     gain_reg  <= cfg_data[15:0];
                    CFG_RESAMPLE:   rstep_reg <= cfg_data[21:0];
                    default:        ;
                endcase
            end

            if (item_valid && item_ready)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;

            if (s2_adv)
                s3_valid_reg <= 1'b1;
            else if (s3_adv)
                s3_valid_reg <= 1'b0;

            if (s3_adv)
                s4_valid_reg <= 1'b1;
            else if (s4_adv)
                s4_valid_reg <= 1'b0;

            // phase and fraction move once per tick, in order
            if (s2_adv)
            begin
                phase_reg <= phase_reg + s2_incr_reg;
                frac_reg  <= frac_sum[15:0];
            end

            // repeat the held sample, one beat per cycle while result_ready is high
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                rem_reg       <= s4_count_reg;
            end
            else if (result_valid && result_ready)
            begin
                if (rem_reg == 7'd1)
                    out_valid_reg <= 1'b0;
                else
                    rem_reg <= rem_reg - 7'd1;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_rpm_reg <= item.rpm;
            s1_ign_reg <= item.ignition_on;
        end
        if (s1_adv)
        begin
            s2_incr_reg   <= s1_active ? incr_wide[PHASE_BITS-1:0] : '0;
            s2_active_reg <= s1_active;
        end
        if (s2_adv)
        begin
            s3_neg_reg    <= idx[SINE_ADDR_BITS-1];
            s3_active_reg <= s2_active_reg;
            s3_count_reg  <= frac_sum[22:16];
        end
        if (s3_adv)
        begin
            s4_gprod_reg  <= 47'(s3_sine) * 47'(gain_reg);
            s4_neg_reg    <= s3_neg_reg;
            s4_active_reg <= s3_active_reg;
            s4_count_reg  <= s3_count_reg;
        end
        if (out_load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign result_valid       = out_valid_reg;
    assign result.sample_out  = sample_reg;
    assign result.last_of_run = (rem_reg == 7'd1);

    // ---- checks ----
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rem_reg != 7'd0 && rem_reg <= 7'd64))
        else $error("repeat count out of range while holding a beat");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result.last_of_run) |=> result_valid)
        else $error("run ended before its last copy");

    a_silent_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && !s2_active_reg) |=> $stable(phase_reg))
        else $error("phase moved on a silent tick");

    a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_adv |=> ($stable(phase_reg) && $stable(frac_reg)))
        else $error("oscillator state moved without a tick");

endmodule
